[sv/cls_pkg.sv]
// shared types and constants for the consensus log store
// operation and status codes, sequencer states, response and queue status structs
// no dependencies
`default_nettype none

package cls_pkg;

   localparam int WORD_W           = 32;
   localparam int OP_W             = 3;
   localparam int STAT_W           = 3;
   localparam int LOG_DEPTH_DEF    = 64;
   localparam int PAYLOAD_BITS_DEF = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_TERM_QUERY = 3'd0;
   localparam logic [OP_W-1:0] OP_RANGE_READ = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND     = 3'd2;
   localparam logic [OP_W-1:0] OP_PREV_CHECK = 3'd3;
   localparam logic [OP_W-1:0] OP_OFFER      = 3'd4;
   localparam logic [OP_W-1:0] OP_COMPACT    = 3'd5;
   localparam logic [OP_W-1:0] OP_INSTALL    = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_REJECT  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOKUP,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] index_out;
      logic [WORD_W-1:0] term_out;
      logic [WORD_W-1:0] payload_out;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } q_stat_type;

endpackage

`default_nettype wire

[sv/cls_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module cls_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/cls_rsp_queue.sv]
// two-entry response queue between the sequencer and the rsp_ channel
// depends on cls_pkg
`default_nettype none

module cls_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cls_pkg::rsp_item_type push_item,
   output cls_pkg::q_stat_type   q_stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cls_pkg::rsp_item_type rsp_item
);

   import cls_pkg::*;

   rsp_item_type item_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = item_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign q_stat.count = count_ff;
   assign q_stat.pop   = pop;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("response queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      push |-> !(count_ff == 2'd2 && !pop))
      else $error("push into a full response queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd0) |=> rsp_valid)
      else $error("pushed response did not show up");
`endif

endmodule

`default_nettype wire

[sv/cls_ctrl.sv]
// log sequencer: snapshot and ring pointers, follower cursor, operation decode,
// ram read-modify-write and range streaming; depends on cls_pkg
`default_nettype none

module cls_ctrl #(
   parameter int LOG_DEPTH    = cls_pkg::LOG_DEPTH_DEF,
   parameter int PAYLOAD_BITS = cls_pkg::PAYLOAD_BITS_DEF,
   localparam int SLOT_W = $clog2(LOG_DEPTH),
   localparam int PL_W   = (PAYLOAD_BITS < cls_pkg::WORD_W) ? PAYLOAD_BITS : cls_pkg::WORD_W,
   localparam int RAM_W  = cls_pkg::WORD_W + PL_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cls_pkg::OP_W-1:0]    req_operation,
   input  logic [cls_pkg::WORD_W-1:0]  req_index,
   input  logic [cls_pkg::WORD_W-1:0]  req_end_index,
   input  logic [cls_pkg::WORD_W-1:0]  req_term,
   input  logic [cls_pkg::WORD_W-1:0]  req_payload,
   input  cls_pkg::q_stat_type         q_stat,
   output logic                        push,
   output cls_pkg::rsp_item_type       push_item,
   output logic                        ram_wr_en,
   output logic [SLOT_W-1:0]           ram_wr_addr,
   output logic [RAM_W-1:0]            ram_wr_data,
   output logic                        ram_rd_en,
   output logic [SLOT_W-1:0]           ram_rd_addr,
   input  logic [RAM_W-1:0]            ram_rd_data
);

   import cls_pkg::*;

   localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
   localparam int WRAP_W = SLOT_W + 1;
   localparam logic [WORD_W:0] LAST_MAX = {1'b0, {WORD_W{1'b1}}};

   // ring slot arithmetic: h + n where h < depth and n <= depth
   function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0] n);
      logic [WRAP_W-1:0] sum;
      sum = WRAP_W'(h) + WRAP_W'(n);
      if (sum >= WRAP_W'(LOG_DEPTH)) begin
         sum = sum - WRAP_W'(LOG_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [WORD_W-1:0] idx_ff, eidx_ff, tm_ff;
   logic [PL_W-1:0]   pl_ff;

   // log state
   logic [WORD_W-1:0] snap_idx_ff, snap_idx_in;
   logic [WORD_W-1:0] snap_term_ff, snap_term_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              armed_ff, armed_in;
   logic [WORD_W-1:0] cursor_ff, cursor_in;

   // range streaming
   logic [WORD_W-1:0] strm_index_ff, strm_index_in;
   logic [CNT_W-1:0]  strm_left_ff, strm_left_in;
   logic [SLOT_W-1:0] strm_slot_ff, strm_slot_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [WORD_W-1:0] pend_index_ff, pend_index_in;
   logic              pend_last_ff, pend_last_in;

   // decode terms
   logic [WORD_W:0]   snap33, first_w, last_w, last_p1, idx33, eidx33, cur33;
   logic [WORD_W:0]   from_w, to_w, idx_off, cur_off, from_off, span_w;
   logic [WORD_W-1:0] drop_w, trunc_w;
   logic              idx_stored, fixed_hit, full, range_empty, need_read;
   logic [WORD_W-1:0] fixed_term, chk_term, rd_term;
   logic [PL_W-1:0]   rd_pl;
   logic [SLOT_W-1:0] tail_slot, idx_slot, cur_slot, from_slot;
   logic              pop, room_dec, fire;
   logic [2:0]        strm_used;
   logic              room_strm;

   assign req_stall = (state_ff != ST_IDLE);
   assign pop       = q_stat.pop;

   always_comb begin
      snap33      = {1'b0, snap_idx_ff};
      first_w     = snap33 + (WORD_W + 1)'(1);
      last_w      = snap33 + (WORD_W + 1)'(count_ff);
      last_p1     = last_w + (WORD_W + 1)'(1);
      idx33       = {1'b0, idx_ff};
      eidx33      = {1'b0, eidx_ff};
      cur33       = {1'b0, cursor_ff};
      idx_stored  = (idx33 >= first_w) && (idx33 <= last_w);
      fixed_hit   = (idx_ff == '0) || (idx_ff == snap_idx_ff);
      fixed_term  = (idx_ff == '0) ? '0 : snap_term_ff;
      full        = (count_ff >= CNT_W'(LOG_DEPTH)) || (last_w >= LAST_MAX);
      from_w      = (idx33 < first_w) ? first_w : idx33;
      to_w        = (eidx33 > last_p1) ? last_p1 : eidx33;
      range_empty = (idx_ff >= eidx_ff) || (from_w >= to_w);
      span_w      = to_w - from_w;
      idx_off     = idx33 - first_w;
      cur_off     = cur33 - first_w;
      from_off    = from_w - first_w;
      drop_w      = idx_ff - snap_idx_ff;
      trunc_w     = cursor_ff - snap_idx_ff;
      tail_slot   = wrap_add(head_ff, count_ff);
      idx_slot    = wrap_add(head_ff, idx_off[CNT_W-1:0]);
      cur_slot    = wrap_add(head_ff, cur_off[CNT_W-1:0]);
      from_slot   = wrap_add(head_ff, from_off[CNT_W-1:0]);
      rd_term     = ram_rd_data[RAM_W-1 -: WORD_W];
      rd_pl       = ram_rd_data[PL_W-1:0];
      chk_term    = (state_ff == ST_LOOKUP) ? rd_term : fixed_term;
      room_dec    = !(q_stat.count == 2'd2 && !pop);
      fire        = (state_ff == ST_DECODE) && room_dec;
      strm_used   = 3'(q_stat.count) + 3'(rd_pend_ff) - 3'(pop);
      room_strm   = (strm_used < 3'd2);
   end

   always_comb begin
      case (op_ff)
         OP_TERM_QUERY, OP_PREV_CHECK: need_read = !fixed_hit && idx_stored;
         OP_OFFER: need_read = armed_ff && (cur33 > snap33) && (cur33 <= last_w);
         default:  need_read = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (fire) begin
               if (op_ff == OP_RANGE_READ && !range_empty) begin
                  state_in = ST_STREAM;
               end else if (need_read) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOOKUP: state_in = ST_IDLE;
         ST_STREAM: begin
            if (strm_left_ff == '0 && rd_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      snap_idx_in   = snap_idx_ff;
      snap_term_in  = snap_term_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      armed_in      = armed_ff;
      cursor_in     = cursor_ff;
      strm_index_in = strm_index_ff;
      strm_left_in  = strm_left_ff;
      strm_slot_in  = strm_slot_ff;
      rd_pend_in    = 1'b0;
      pend_index_in = pend_index_ff;
      pend_last_in  = pend_last_ff;
      push          = 1'b0;
      push_item     = '0;
      push_item.last = 1'b1;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail_slot;
      ram_wr_data   = {tm_ff, pl_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_slot;

      case (state_ff)
         ST_DECODE: begin
            if (fire) begin
               case (op_ff)
                  OP_TERM_QUERY: begin
                     if (fixed_hit) begin
                        push                = 1'b1;
                        push_item.status    = STAT_OK;
                        push_item.index_out = idx_ff;
                        push_item.term_out  = fixed_term;
                     end else if (idx_stored) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_slot;
                     end else begin
                        push                = 1'b1;
                        push_item.status    = STAT_REJECT;
                        push_item.index_out = idx_ff;
                     end
                  end
                  OP_RANGE_READ: begin
                     if (range_empty) begin
                        push             = 1'b1;
                        push_item.status = STAT_EMPTY;
                     end else begin
                        strm_index_in = from_w[WORD_W-1:0];
                        strm_left_in  = span_w[CNT_W-1:0];
                        strm_slot_in  = from_slot;
                     end
                  end
                  OP_APPEND: begin
                     push = 1'b1;
                     if (full) begin
                        push_item.status = STAT_FULL;
                     end else begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = tail_slot;
                        count_in            = count_ff + CNT_W'(1);
                        push_item.status    = STAT_OK;
                        push_item.index_out = last_p1[WORD_W-1:0];
                     end
                  end
                  OP_PREV_CHECK: begin
                     armed_in = 1'b0;
                     if (fixed_hit) begin
                        push = 1'b1;
                        if (chk_term != tm_ff) begin
                           push_item.status = STAT_REJECT;
                        end else if (idx_ff == '1) begin
                           push_item.status = STAT_FULL;
                        end else begin
                           armed_in         = 1'b1;
                           cursor_in        = idx_ff + WORD_W'(1);
                           push_item.status = STAT_OK;
                        end
                     end else if (idx_stored) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_slot;
                     end else begin
                        push             = 1'b1;
                        push_item.status = STAT_REJECT;
                     end
                  end
                  OP_OFFER: begin
                     if (!armed_ff) begin
                        push             = 1'b1;
                        push_item.status = STAT_IGNORED;
                     end else if (cur33 <= snap33) begin
                        // already covered by the snapshot
                        push             = 1'b1;
                        cursor_in        = cursor_ff + WORD_W'(1);
                        push_item.status = STAT_OK;
                     end else if (cur33 <= last_w) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_slot;
                     end else if (cur33 == last_p1) begin
                        push = 1'b1;
                        if (full) begin
                           push_item.status = STAT_FULL;
                        end else begin
                           ram_wr_en        = 1'b1;
                           ram_wr_addr      = tail_slot;
                           count_in         = count_ff + CNT_W'(1);
                           cursor_in        = cursor_ff + WORD_W'(1);
                           push_item.status = STAT_OK;
                        end
                     end else begin
                        push             = 1'b1;
                        armed_in         = 1'b0;
                        push_item.status = STAT_REJECT;
                     end
                  end
                  OP_COMPACT: begin
                     push = 1'b1;
                     if (idx_ff <= snap_idx_ff) begin
                        push_item.status = STAT_IGNORED;
                     end else begin
                        push_item.status = STAT_OK;
                        snap_idx_in      = idx_ff;
                        snap_term_in     = tm_ff;
                        armed_in         = 1'b0;
                        if (idx33 > last_w) begin
                           head_in  = '0;
                           count_in = '0;
                        end else begin
                           head_in  = wrap_add(head_ff, drop_w[CNT_W-1:0]);
                           count_in = count_ff - drop_w[CNT_W-1:0];
                        end
                     end
                  end
                  OP_INSTALL: begin
                     push             = 1'b1;
                     push_item.status = STAT_OK;
                     snap_idx_in      = idx_ff;
                     snap_term_in     = tm_ff;
                     head_in          = '0;
                     count_in         = '0;
                     armed_in         = 1'b0;
                  end
                  default: begin
                     push             = 1'b1;
                     push_item.status = STAT_IGNORED;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            // queue room was reserved when the read was issued
            case (op_ff)
               OP_TERM_QUERY: begin
                  push                = 1'b1;
                  push_item.status    = STAT_OK;
                  push_item.index_out = idx_ff;
                  push_item.term_out  = rd_term;
               end
               OP_PREV_CHECK: begin
                  push     = 1'b1;
                  armed_in = 1'b0;
                  if (chk_term != tm_ff) begin
                     push_item.status = STAT_REJECT;
                  end else if (idx_ff == '1) begin
                     push_item.status = STAT_FULL;
                  end else begin
                     armed_in         = 1'b1;
                     cursor_in        = idx_ff + WORD_W'(1);
                     push_item.status = STAT_OK;
                  end
               end
               OP_OFFER: begin
                  push             = 1'b1;
                  push_item.status = STAT_OK;
                  cursor_in        = cursor_ff + WORD_W'(1);
                  if (rd_term != tm_ff) begin
                     // conflict: cut the log at the cursor and rewrite that slot
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = cur_slot;
                     count_in            = trunc_w[CNT_W-1:0];
                     push_item.index_out = cursor_ff;
                  end
               end
               default: begin
                  push = 1'b0;
               end
            endcase
         end
         ST_STREAM: begin
            if (rd_pend_ff) begin
               push                  = 1'b1;
               push_item.status      = STAT_OK;
               push_item.index_out   = pend_index_ff;
               push_item.term_out    = rd_term;
               push_item.payload_out = WORD_W'(rd_pl);
               push_item.last        = pend_last_ff;
            end
            if (strm_left_ff != '0 && room_strm) begin
               ram_rd_en     = 1'b1;
               ram_rd_addr   = strm_slot_ff;
               rd_pend_in    = 1'b1;
               pend_index_in = strm_index_ff;
               pend_last_in  = (strm_left_ff == CNT_W'(1));
               strm_index_in = strm_index_ff + WORD_W'(1);
               strm_left_in  = strm_left_ff - CNT_W'(1);
               strm_slot_in  = wrap_add(strm_slot_ff, CNT_W'(1));
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         snap_idx_ff  <= '0;
         snap_term_ff <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         cursor_ff    <= '0;
         strm_left_ff <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         snap_idx_ff  <= snap_idx_in;
         snap_term_ff <= snap_term_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         cursor_ff    <= cursor_in;
         strm_left_ff <= strm_left_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff   <= req_operation;
         idx_ff  <= req_index;
         eidx_ff <= req_end_index;
         tm_ff   <= req_term;
         pl_ff   <= req_payload[PL_W-1:0];
      end
      strm_index_ff <= strm_index_in;
      strm_slot_ff  <= strm_slot_in;
      pend_index_ff <= pend_index_in;
      pend_last_ff  <= pend_last_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(LOG_DEPTH))
      else $error("entry count exceeds ring depth");
   assert property (@(posedge clock) disable iff (reset)
      WRAP_W'(head_ff) < WRAP_W'(LOG_DEPTH))
      else $error("head slot outside ring");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> $past(ram_rd_en))
      else $error("lookup without a ram read");
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_DECODE || state_ff == ST_LOOKUP))
      else $error("ram write outside decode or lookup");
`endif

endmodule

`default_nettype wire

[sv/consensus_log_store_core.sv]
// consensus log store: replicated log in a ring memory behind a snapshot point
// top level; depends on cls_pkg, cls_ram, cls_rsp_queue, cls_ctrl
//
// one operation is a transfer on the req_ channel; every operation gives one or more
// transfers on the rsp_ channel, the final one with rsp_last high. term query, append,
// prev check without a ram read, offer entry without a ram read, compact, install and
// unknown operations go through accept, then decode and update. term query, prev check
// and offer entry on a stored index add a lookup state after decode, since the ring
// ram has a registered read. a range read streams its entries through the
// single ram read port, one entry per cycle while the consumer keeps up. only
// one operation is in flight; the next is taken as soon as the previous one has
// written its result into the two-entry response queue, so a waiting response does
// not hold off the next request. no ram write can overlap a read of the same slot.
// entries that were never written have no reset value and need no clearing pass; the
// log comes out of reset empty with snapshot (0, 0).
`default_nettype none

module consensus_log_store_core #(
   parameter int LOG_DEPTH    = cls_pkg::LOG_DEPTH_DEF,
   parameter int PAYLOAD_BITS = cls_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cls_pkg::OP_W-1:0]      req_operation,
   input  logic [cls_pkg::WORD_W-1:0]    req_index,
   input  logic [cls_pkg::WORD_W-1:0]    req_end_index,
   input  logic [cls_pkg::WORD_W-1:0]    req_term,
   input  logic [cls_pkg::WORD_W-1:0]    req_payload,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cls_pkg::STAT_W-1:0]    rsp_status,
   output logic [cls_pkg::WORD_W-1:0]    rsp_index_out,
   output logic [cls_pkg::WORD_W-1:0]    rsp_term_out,
   output logic [cls_pkg::WORD_W-1:0]    rsp_payload_out,
   output logic                          rsp_last
);

   import cls_pkg::*;

   // payload bits kept per entry: the request payload is only a word wide
   localparam int SLOT_W = $clog2(LOG_DEPTH);
   localparam int PL_W   = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
   localparam int RAM_W  = WORD_W + PL_W;

   // sequencer to queue
   logic         push;
   rsp_item_type push_item;
   q_stat_type   q_stat;
   rsp_item_type rsp_item;

   // ring ram, one entry is {term, payload}
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [RAM_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [RAM_W-1:0]  ram_rd_data;

   cls_ctrl #(
      .LOG_DEPTH    (LOG_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_end_index (req_end_index),
      .req_term      (req_term),
      .req_payload   (req_payload),
      .q_stat        (q_stat),
      .push          (push),
      .push_item     (push_item),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   cls_ram #(
      .WIDTH (RAM_W),
      .DEPTH (LOG_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register plus skid entry
   cls_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .q_stat    (q_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_status      = rsp_item.status;
   assign rsp_index_out   = rsp_item.index_out;
   assign rsp_term_out    = rsp_item.term_out;
   assign rsp_payload_out = rsp_item.payload_out;
   assign rsp_last        = rsp_item.last;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for consensus_log_store_core: random and directed log operations
// holds its own model of the ring log; depends on cls_pkg and the core's rtl
`timescale 1ns / 100ps

module testbench;
   import cls_pkg::*;

   localparam int DEPTH       = LOG_DEPTH_DEF;
   localparam int PAY_BITS    = PAYLOAD_BITS_DEF;
   localparam int RAND_ITEMS  = 260;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [OP_W-1:0]   OP_UNUSED = 3'd7;
   localparam logic [WORD_W-1:0] TOP_INDEX = 32'hFFFFFFFF;
   localparam logic [WORD_W-1:0] PAY_MASK  =
      (PAY_BITS >= 32) ? 32'hFFFFFFFF : ((32'd1 << PAY_BITS) - 32'd1);

   typedef logic [33:0] wide_type;

   // one request as queued for the driver, with the number of responses it causes
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] idx;
      logic [WORD_W-1:0] end_idx;
      logic [WORD_W-1:0] trm;
      logic [WORD_W-1:0] pay;
      logic              drain;
      logic [7:0]        nres;
   } log_req_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [WORD_W-1:0]   req_index     = '0;
   logic [WORD_W-1:0]   req_end_index = '0;
   logic [WORD_W-1:0]   req_term      = '0;
   logic [WORD_W-1:0]   req_payload   = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [WORD_W-1:0]   rsp_index_out;
   logic [WORD_W-1:0]   rsp_term_out;
   logic [WORD_W-1:0]   rsp_payload_out;
   logic                rsp_last;

   consensus_log_store_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_index       (req_index),
      .req_end_index   (req_end_index),
      .req_term        (req_term),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_index_out   (rsp_index_out),
      .rsp_term_out    (rsp_term_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // log model: snapshot point plus ring of stored entries
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] snap_idx   = '0;
   logic [WORD_W-1:0] snap_trm   = '0;
   int                ring_head  = 0;
   int                ring_count = 0;
   logic [WORD_W-1:0] ring_term [DEPTH];
   logic [WORD_W-1:0] ring_pay  [DEPTH];
   logic              follow_on  = 1'b0;
   logic [WORD_W-1:0] follow_at  = '0;

   log_req_type  pending[$];       // requests not yet transferred, in order
   rsp_item_type planned_rsp[$];   // responses of requests still in pending
   rsp_item_type awaited_rsp[$];   // responses of transferred requests, oldest first

   int  err_cnt    = 0;
   int  taken_cnt  = 0;
   int  rsp_cnt    = 0;
   int  full_cnt   = 0;
   int  op_seen [8];
   bit  long_hold  = 1'b0;
   bit  drain_next = 1'b0;
   int  cycle_cnt;

   function automatic wide_type last_idx();
      return wide_type'(snap_idx) + wide_type'(ring_count);
   endfunction

   function automatic int slot_of(wide_type i);
      wide_type off;
      off = i - wide_type'(snap_idx) - wide_type'(1);
      return (ring_head + int'(off[6:0])) % DEPTH;
   endfunction

   // term of an index when it is known: 0, the snapshot point or a stored entry
   function automatic bit lookup_term(wide_type i, output logic [WORD_W-1:0] t);
      t = '0;
      if (i == wide_type'(0)) return 1'b1;
      if (i == wide_type'(snap_idx)) begin
         t = snap_trm;
         return 1'b1;
      end
      if (i <= wide_type'(snap_idx) || i > last_idx()) return 1'b0;
      t = ring_term[slot_of(i)];
      return 1'b1;
   endfunction

   function automatic bit push_entry(logic [WORD_W-1:0] t, logic [WORD_W-1:0] p);
      int s;
      if (ring_count >= DEPTH || last_idx() >= wide_type'(TOP_INDEX)) return 1'b0;
      s = (ring_head + ring_count) % DEPTH;
      ring_term[s] = t;
      ring_pay[s]  = p & PAY_MASK;
      ring_count++;
      return 1'b1;
   endfunction

   function automatic void drop_all(logic [WORD_W-1:0] i, logic [WORD_W-1:0] t);
      ring_count = 0;
      ring_head  = 0;
      snap_idx   = i;
      snap_trm   = t;
      follow_on  = 1'b0;
   endfunction

   function automatic void add_rsp(logic [STAT_W-1:0] st, logic [WORD_W-1:0] i,
                                   logic [WORD_W-1:0] t, logic [WORD_W-1:0] p, logic l);
      rsp_item_type x;
      x.status      = st;
      x.index_out   = i;
      x.term_out    = t;
      x.payload_out = p;
      x.last        = l;
      planned_rsp.push_back(x);
   endfunction

   // applies one request to the log model, queues its responses, returns their number
   function automatic int log_step(log_req_type r);
      logic [WORD_W-1:0] t;
      wide_type          lo, hi, cur, w;
      int                start_cnt, s, drop;
      start_cnt = planned_rsp.size();
      case (r.op)
         OP_TERM_QUERY: begin
            if (lookup_term(wide_type'(r.idx), t)) add_rsp(STAT_OK, r.idx, t, '0, 1'b1);
            else add_rsp(STAT_REJECT, r.idx, '0, '0, 1'b1);
         end
         OP_RANGE_READ: begin
            // clamp to the stored span
            lo = wide_type'(r.idx);
            hi = wide_type'(r.end_idx);
            if (lo < wide_type'(snap_idx) + wide_type'(1))
               lo = wide_type'(snap_idx) + wide_type'(1);
            if (hi > last_idx() + wide_type'(1)) hi = last_idx() + wide_type'(1);
            if (r.idx >= r.end_idx || lo >= hi) add_rsp(STAT_EMPTY, '0, '0, '0, 1'b1);
            else begin
               for (w = lo; w < hi; w++) begin
                  s = slot_of(w);
                  add_rsp(STAT_OK, w[31:0], ring_term[s], ring_pay[s],
                          w + wide_type'(1) == hi);
               end
            end
         end
         OP_APPEND: begin
            if (push_entry(r.trm, r.pay)) begin
               w = last_idx();
               add_rsp(STAT_OK, w[31:0], '0, '0, 1'b1);
            end else add_rsp(STAT_FULL, '0, '0, '0, 1'b1);
         end
         OP_PREV_CHECK: begin
            follow_on = 1'b0;
            if (!lookup_term(wide_type'(r.idx), t) || t != r.trm)
               add_rsp(STAT_REJECT, '0, '0, '0, 1'b1);
            else if (r.idx == TOP_INDEX) add_rsp(STAT_FULL, '0, '0, '0, 1'b1);
            else begin
               follow_on = 1'b1;
               follow_at = r.idx + 32'd1;
               add_rsp(STAT_OK, '0, '0, '0, 1'b1);
            end
         end
         OP_OFFER: begin
            cur = wide_type'(follow_at);
            if (!follow_on) add_rsp(STAT_IGNORED, '0, '0, '0, 1'b1);
            else if (cur <= wide_type'(snap_idx)) begin
               // already covered by the snapshot
               follow_at++;
               add_rsp(STAT_OK, '0, '0, '0, 1'b1);
            end else if (cur <= last_idx()) begin
               if (ring_term[slot_of(cur)] == r.trm) begin
                  follow_at++;
                  add_rsp(STAT_OK, '0, '0, '0, 1'b1);
               end else begin
                  // conflict: cut the suffix from the cursor, then append
                  w = cur - wide_type'(snap_idx) - wide_type'(1);
                  ring_count = int'(w[7:0]);
                  void'(push_entry(r.trm, r.pay));
                  follow_at++;
                  add_rsp(STAT_OK, cur[31:0], '0, '0, 1'b1);
               end
            end else if (cur == last_idx() + wide_type'(1)) begin
               if (!push_entry(r.trm, r.pay)) add_rsp(STAT_FULL, '0, '0, '0, 1'b1);
               else begin
                  follow_at++;
                  add_rsp(STAT_OK, '0, '0, '0, 1'b1);
               end
            end else begin
               follow_on = 1'b0;
               add_rsp(STAT_REJECT, '0, '0, '0, 1'b1);
            end
         end
         OP_COMPACT: begin
            if (r.idx <= snap_idx) add_rsp(STAT_IGNORED, '0, '0, '0, 1'b1);
            else begin
               if (wide_type'(r.idx) > last_idx()) drop_all(r.idx, r.trm);
               else begin
                  drop       = int'(r.idx - snap_idx);
                  ring_head  = (ring_head + drop) % DEPTH;
                  ring_count = ring_count - drop;
                  snap_idx   = r.idx;
                  snap_trm   = r.trm;
                  follow_on  = 1'b0;
               end
               add_rsp(STAT_OK, '0, '0, '0, 1'b1);
            end
         end
         OP_INSTALL: begin
            drop_all(r.idx, r.trm);
            add_rsp(STAT_OK, '0, '0, '0, 1'b1);
         end
         default: add_rsp(STAT_IGNORED, '0, '0, '0, 1'b1);
      endcase
      return planned_rsp.size() - start_cnt;
   endfunction

   // queues one request with its predicted responses; returns 1 unless it is ignored
   function automatic bit gen_push(logic [OP_W-1:0] op, logic [WORD_W-1:0] idx,
                                   logic [WORD_W-1:0] eidx, logic [WORD_W-1:0] trm,
                                   logic [WORD_W-1:0] pay);
      log_req_type r;
      int          n;
      r.op      = op;
      r.idx     = idx;
      r.end_idx = eidx;
      r.trm     = trm;
      r.pay     = pay;
      r.drain   = drain_next;
      r.nres    = '0;
      drain_next = 1'b0;
      n = log_step(r);
      r.nres = n[7:0];
      pending.push_back(r);
      return planned_rsp[planned_rsp.size() - n].status != STAT_IGNORED;
   endfunction

   // an index a little below the snapshot up to a little past the last entry
   function automatic logic [WORD_W-1:0] near_idx(int below, int above);
      longint v;
      v = longint'(snap_idx) - below + $urandom_range(0, ring_count + below + above);
      return v[31:0];
   endfunction

   // ------------------------------------------------------------------
   // stimulus: all requests are planned at time zero, then the run is watched
   // ------------------------------------------------------------------
   initial begin : stimulus
      int                counted;
      int                pick;
      int                k;
      logic [WORD_W-1:0] gen_term;
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] t;
      counted  = 0;
      gen_term = 32'd10;

      // directed: field extremes, every operation, follower corner cases
      void'(gen_push(OP_TERM_QUERY, '0, '0, '0, '0));
      void'(gen_push(OP_TERM_QUERY, TOP_INDEX, TOP_INDEX, TOP_INDEX, TOP_INDEX));
      void'(gen_push(OP_RANGE_READ, '0, TOP_INDEX, '0, '0));          // empty log
      void'(gen_push(OP_APPEND, '0, '0, 32'd1, TOP_INDEX));
      void'(gen_push(OP_APPEND, '0, '0, TOP_INDEX, '0));
      void'(gen_push(OP_APPEND, '0, '0, 32'd2, 32'hA5A55A5A));
      void'(gen_push(OP_RANGE_READ, '0, TOP_INDEX, '0, '0));          // clamped span
      void'(gen_push(OP_RANGE_READ, 32'd3, 32'd2, '0, '0));           // start past end
      void'(gen_push(OP_TERM_QUERY, 32'd2, '0, '0, '0));
      void'(gen_push(OP_PREV_CHECK, 32'd1, '0, 32'd1, '0));           // arms at 2
      void'(gen_push(OP_OFFER, '0, '0, TOP_INDEX, 32'd7));            // matching term
      void'(gen_push(OP_OFFER, '0, '0, 32'd5, 32'd8));                // conflict at 3
      void'(gen_push(OP_OFFER, '0, '0, 32'd5, 32'd9));                // one past the end: appends
      void'(gen_push(OP_PREV_CHECK, 32'd2, '0, 32'd7, '0));           // wrong term
      void'(gen_push(OP_OFFER, '0, '0, 32'd5, '0));                   // disarmed
      void'(gen_push(OP_COMPACT, '0, '0, 32'd4, '0));                 // at the snapshot
      void'(gen_push(OP_COMPACT, 32'd2, '0, TOP_INDEX, '0));
      void'(gen_push(OP_TERM_QUERY, 32'd2, '0, '0, '0));              // snapshot term
      void'(gen_push(OP_PREV_CHECK, '0, '0, '0, '0));                 // arms at 1
      void'(gen_push(OP_OFFER, '0, '0, 32'd3, '0));                   // under the snapshot
      void'(gen_push(OP_UNUSED, TOP_INDEX, TOP_INDEX, TOP_INDEX, TOP_INDEX));
      void'(gen_push(OP_INSTALL, 32'hFFFFFFFE, '0, 32'd9, '0));
      void'(gen_push(OP_APPEND, '0, '0, 32'd9, 32'h12345678));        // index at the top
      void'(gen_push(OP_APPEND, '0, '0, 32'd9, '0));                  // no index left
      void'(gen_push(OP_PREV_CHECK, TOP_INDEX, '0, 32'd9, '0));       // no room after it

      // random part opens with a drained pause and a fill of the whole ring
      drain_next = 1'b1;
      counted += gen_push(OP_INSTALL, $urandom_range(0, 100), $urandom,
                          $urandom_range(0, 5), $urandom);
      pick = 100;
      while (pending.size() < RAND_ITEMS) begin
         if (!drain_next && counted >= RAND_ITEMS / 2 && counted < RAND_ITEMS / 2 + 4)
            drain_next = 1'b1;
         if (pick == 100 || pick == 82) begin
            // fill until full, one more append, a prev check at the last entry, then an offer into the full ring
            while (ring_count < DEPTH && last_idx() < wide_type'(TOP_INDEX))
               counted += gen_push(OP_APPEND, $urandom, $urandom, gen_term, $urandom);
            counted += gen_push(OP_APPEND, $urandom, $urandom, gen_term, $urandom);
            void'(lookup_term(last_idx(), t));
            p = 32'(last_idx());
            counted += gen_push(OP_PREV_CHECK, p, $urandom, t, $urandom);
            counted += gen_push(OP_OFFER, $urandom, $urandom, gen_term + 32'd1, $urandom);
         end else if (pick < 25) begin
            k = $urandom_range(1, 8);
            repeat (k) begin
               gen_term += $urandom_range(0, 1);
               counted += gen_push(OP_APPEND, $urandom, $urandom,
                                   ($urandom_range(0, 7) == 0) ? $urandom : gen_term,
                                   $urandom);
            end
         end else if (pick < 50) begin
            // follower append: prev check, then a run of offered entries
            p = near_idx(1, 1);
            if ($urandom_range(0, 9) == 0) p = '0;
            if (!lookup_term(wide_type'(p), t) || $urandom_range(0, 6) == 0)
               t = ($urandom_range(0, 3) == 0) ? $urandom : gen_term;
            counted += gen_push(OP_PREV_CHECK, p, $urandom, t, $urandom);
            k = $urandom_range(1, 6);
            repeat (k) begin
               if (!(lookup_term(wide_type'(follow_at), t) && $urandom_range(0, 9) < 6))
               begin
                  gen_term += $urandom_range(0, 1);
                  t = ($urandom_range(0, 3) == 0) ? $urandom : gen_term;
               end
               counted += gen_push(OP_OFFER, $urandom, $urandom, t, $urandom);
            end
         end else if (pick < 70) begin
            k = $urandom_range(1, 3);
            repeat (k) begin
               p = near_idx(2, 2);
               if ($urandom_range(0, 1) == 0)
                  counted += gen_push(OP_TERM_QUERY, p, $urandom, $urandom, $urandom);
               else if ($urandom_range(0, 9) == 0)
                  counted += gen_push(OP_RANGE_READ, p, p + 32'd70, $urandom, $urandom);
               else if ($urandom_range(0, 19) == 0)
                  counted += gen_push(OP_RANGE_READ, p, p - $urandom_range(0, 3),
                                      $urandom, $urandom);
               else
                  counted += gen_push(OP_RANGE_READ, p, p + $urandom_range(0, 8),
                                      $urandom, $urandom);
            end
         end else if (pick < 78) begin
            p = ($urandom_range(0, 6) == 0) ? near_idx(2, 0) - 32'd1 : near_idx(0, 3);
            if (!lookup_term(wide_type'(p), t)) t = $urandom;
            counted += gen_push(OP_COMPACT, p, $urandom, t, $urandom);
         end else if (pick < 81) begin
            k = $urandom_range(0, 4);
            if (k < 3) p = $urandom_range(0, 200);
            else if (k == 3) p = TOP_INDEX - $urandom_range(0, 80);
            else p = $urandom;
            counted += gen_push(OP_INSTALL, p, $urandom, $urandom_range(0, 3) == 0 ?
                                $urandom : gen_term, $urandom);
         end else begin
            // noise: any operation code and any field values
            k = $urandom_range(1, 3);
            repeat (k)
               counted += gen_push(OP_W'($urandom_range(0, 7)), $urandom, $urandom,
                                   $urandom, $urandom);
         end
         pick = $urandom_range(0, 99);
         if (pick == 100 || (pick == 82 && $urandom_range(0, 1) == 0)) pick = 82;
         else if (pick == 82) pick = 83;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait until every request is transferred and every response checked
      while (pending.size() != 0 || awaited_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d requests: %0d range reads, %0d appends, %0d offers, %0d compacts",
               taken_cnt, op_seen[OP_RANGE_READ], op_seen[OP_APPEND], op_seen[OP_OFFER],
               op_seen[OP_COMPACT]);
      $display("checked %0d response transfers, %0d of them log full", rsp_cnt, full_cnt);
      if (err_cnt == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin : watchdog
      for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses still awaited",
               cycle_cnt, awaited_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // request driver: bursts of transfers with random gaps in between
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : req_driver
      logic        offer;
      log_req_type done_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            // transfer: its responses now become due
            done_req = pending.pop_front();
            repeat (done_req.nres) awaited_rsp.push_back(planned_rsp.pop_front());
            op_seen[done_req.op]++;
            taken_cnt++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         // a stalled request holds its payload
         if (!(req_valid && req_stall)) begin
            offer = 1'b0;
            if (gap_left > 0 && !long_hold) gap_left--;
            else if (pending.size() != 0 && !(pending[0].drain && awaited_rsp.size() != 0))
               offer = 1'b1;
            if (offer) begin
               req_operation <= pending[0].op;
               req_index     <= pending[0].idx;
               req_end_index <= pending[0].end_idx;
               req_term      <= pending[0].trm;
               req_payload   <= pending[0].pay;
            end
            req_valid <= offer;
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor and stall pattern
   // ------------------------------------------------------------------
   int       hold_left = 0;
   bit       hold_done = 1'b0;
   int       stall_cyc = 0;
   int       stall_mode = 0;
   bit [7:0] stall_pat = 8'hFF;

   task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      logic         nxt;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_cnt++;
            if (rsp_status == STAT_FULL) full_cnt++;
            if (awaited_rsp.size() == 0) begin
               $error("response transfer with nothing awaited: status %0d index 0x%0h",
                      rsp_status, rsp_index_out);
               err_cnt++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("index_out", want.index_out, rsp_index_out);
               check_field("term_out", want.term_out, rsp_term_out);
               check_field("payload_out", want.payload_out, rsp_payload_out);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end

         // switch the stall pattern now and then
         stall_cyc++;
         if (stall_cyc % 128 == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_pat  = 8'($urandom);
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b1;
         end else if (!hold_done && taken_cnt >= 80) begin
            // long hold-off so the core backs up and stalls its requests
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            nxt = 1'b1;
         end else begin
            case (stall_mode)
               0: nxt = 1'b0;
               1: nxt = 1'($urandom_range(0, 1));
               2: nxt = stall_pat[stall_cyc % 8];
               default: nxt = ($urandom_range(0, 7) == 0);
            endcase
         end
         long_hold = (hold_left != 0);
         rsp_stall <= nxt;
      end
   end

endmodule

[filelist.f]
sv/cls_pkg.sv
sv/cls_ram.sv
sv/cls_rsp_queue.sv
sv/cls_ctrl.sv
sv/consensus_log_store_core.sv
tb/testbench.sv
